// ----- hw/rtl/avfd_pkg.sv -----
// Shared types and constants for the audio/video frame deframer.
package avfd_pkg;

    localparam int LenW  = 24;
    localparam int ByteW = 8;

    localparam logic [LenW-1:0] LenSat = {LenW{1'b1}};

    // Reset values of the configuration registers
    localparam logic [LenW-1:0]  MaxTotalRst   = 24'd81920;
    localparam logic [ByteW-1:0] SyncFirstRst  = 8'hAA;
    localparam logic [ByteW-1:0] SyncSecondRst = 8'hBB;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_TOTAL   = 2'd0;
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd1;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_VIDEO     = 2'd0;
    localparam logic [1:0] KIND_AUDIO     = 2'd1;
    localparam logic [1:0] KIND_FRAME_END = 2'd2;
    localparam logic [1:0] KIND_ERROR     = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_VIDEO_LEN = 2'd1;
    localparam logic [1:0] ERR_AUDIO_LEN = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_VLEN  = 3'd1,
        PH_VDATA = 3'd2,
        PH_ALEN  = 3'd3,
        PH_ADATA = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t            phase;
        logic [ByteW-1:0]  window_byte;
        logic              window_valid;
        logic [1:0]        len_idx;
        logic [LenW-1:0]   len_accum;
        logic [LenW-1:0]   bytes_left;
        logic [LenW-1:0]   video_length;
    } deframe_state_t;

    typedef struct packed {
        logic              valid;
        logic [ByteW-1:0]  out_byte;
        logic [1:0]        out_kind;
        logic              section_last;
        logic              frame_last;
        logic [1:0]        error_code;
    } deframe_result_t;

endpackage

// ----- hw/rtl/avfd_step.sv -----
// Per-byte deframing logic: next state and optional result word.
module avfd_step
    import avfd_pkg::*;
(
    input  deframe_state_t   st,
    input  logic [ByteW-1:0] rx_byte,
    input  logic [LenW-1:0]  max_total,
    input  logic [ByteW-1:0] sync_first,
    input  logic [ByteW-1:0] sync_second,
    output deframe_state_t   st_next,
    output deframe_result_t  res
);

    logic [LenW-1:0] accum_new;
    logic            len_done;
    logic [LenW-1:0] left_dec;
    logic [LenW-1:0] audio_room;
    logic            video_bad;
    logic            audio_bad;

    // Little-endian length assembly; a nonzero top byte saturates
    always_comb
    begin
        accum_new = st.len_accum;
        case (st.len_idx)
            2'd0: accum_new[7:0]   = st.len_accum[7:0]   | rx_byte;
            2'd1: accum_new[15:8]  = st.len_accum[15:8]  | rx_byte;
            2'd2: accum_new[23:16] = st.len_accum[23:16] | rx_byte;
            default:
            begin
                if (rx_byte != '0)
                    accum_new = LenSat;
            end
        endcase
    end

    assign len_done   = (st.len_idx == 2'd3);
    assign left_dec   = st.bytes_left - 1'b1;
    assign audio_room = max_total - st.video_length;
    assign video_bad  = (accum_new == '0) || (accum_new >= max_total);
    assign audio_bad  = (st.video_length >= max_total) || (accum_new >= audio_room);

    // Phase sequencing
    always_comb
    begin
        st_next = st;
        res     = '0;
        case (st.phase)
            PH_VLEN:
            begin
                st_next.len_accum = accum_new;
                st_next.len_idx   = st.len_idx + 2'd1;
                if (len_done)
                begin
                    if (video_bad)
                    begin
                        st_next.phase        = PH_HUNT;
                        st_next.window_valid = 1'b0;
                        st_next.window_byte  = '0;
                        res.valid      = 1'b1;
                        res.out_kind   = KIND_ERROR;
                        res.error_code = ERR_VIDEO_LEN;
                    end
                    else
                    begin
                        st_next.video_length = accum_new;
                        st_next.bytes_left   = accum_new;
                        st_next.phase        = PH_VDATA;
                    end
                end
            end
            PH_VDATA:
            begin
                st_next.bytes_left = left_dec;
                res.valid    = 1'b1;
                res.out_byte = rx_byte;
                res.out_kind = KIND_VIDEO;
                if (left_dec == '0)
                begin
                    st_next.phase     = PH_ALEN;
                    st_next.len_idx   = 2'd0;
                    st_next.len_accum = '0;
                    res.section_last  = 1'b1;
                end
            end
            PH_ALEN:
            begin
                st_next.len_accum = accum_new;
                st_next.len_idx   = st.len_idx + 2'd1;
                if (len_done)
                begin
                    if (audio_bad || accum_new == '0)
                    begin
                        st_next.phase        = PH_HUNT;
                        st_next.window_valid = 1'b0;
                        st_next.window_byte  = '0;
                        res.valid = 1'b1;
                        if (audio_bad)
                        begin
                            res.out_kind   = KIND_ERROR;
                            res.error_code = ERR_AUDIO_LEN;
                        end
                        else
                        begin
                            res.out_kind   = KIND_FRAME_END;
                            res.frame_last = 1'b1;
                        end
                    end
                    else
                    begin
                        st_next.bytes_left = accum_new;
                        st_next.phase      = PH_ADATA;
                    end
                end
            end
            PH_ADATA:
            begin
                st_next.bytes_left = left_dec;
                res.valid    = 1'b1;
                res.out_byte = rx_byte;
                res.out_kind = KIND_AUDIO;
                if (left_dec == '0)
                begin
                    st_next.phase        = PH_HUNT;
                    st_next.window_valid = 1'b0;
                    st_next.window_byte  = '0;
                    res.section_last     = 1'b1;
                    res.frame_last       = 1'b1;
                end
            end
            default:
            begin
                // Sliding two-byte sync window
                if (st.window_valid && st.window_byte == sync_first
                    && rx_byte == sync_second)
                begin
                    st_next.window_valid = 1'b0;
                    st_next.window_byte  = '0;
                    st_next.phase        = PH_VLEN;
                    st_next.len_idx      = 2'd0;
                    st_next.len_accum    = '0;
                end
                else
                begin
                    st_next.phase        = PH_HUNT;
                    st_next.window_byte  = rx_byte;
                    st_next.window_valid = 1'b1;
                end
            end
        endcase
    end

endmodule

// ----- hw/rtl/av_frame_deframer_core.sv -----
// Top level of the audio/video frame deframer.
//
// Input channel: in_valid/in_ready carry one received byte (rx_byte) per word.
// Output channel: out_valid/out_ready carry one result word: a video or audio
// payload byte, a frame-end marker for frames without audio, or an error.
// Sync bytes give no word; length bytes give one only as an error or frame end.
// Config channel: cfg_valid/cfg_ready with cfg_index/cfg_data; always ready.
// Index 0 is the length limit, 1 and 2 are the sync bytes. Write only when idle.
//
// Each input word is taken into the input register; its result word then goes
// to the output register. Throughput is one word per cycle while the output
// is not stalled; the step logic between the two registers is a single pass.
// When the receiver stalls, the input register still drains words that give
// no result and accepts one more word while the output register holds a
// result; after that in_ready drops until out_ready returns.
// Reset: configuration returns to its defaults, both registers empty, and the
// deframer starts hunting for sync with an empty window.
module av_frame_deframer_core
    import avfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic [1:0]       out_kind,
    output logic             section_last,
    output logic             frame_last,
    output logic [1:0]       error_code,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [23:0]      cfg_data
);

    logic [LenW-1:0]  max_total_reg;
    logic [ByteW-1:0] sync_first_reg;
    logic [ByteW-1:0] sync_second_reg;

    logic             in_valid_reg;
    logic [ByteW-1:0] rx_byte_reg;

    deframe_state_t   st_reg;
    deframe_state_t   st_next;
    deframe_result_t  step_res;
    deframe_result_t  res_reg;

    logic             out_free;
    logic             advance;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_total_reg   <= MaxTotalRst;
            sync_first_reg  <= SyncFirstRst;
            sync_second_reg <= SyncSecondRst;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_TOTAL:   max_total_reg   <= cfg_data;
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data[ByteW-1:0];
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data[ByteW-1:0];
                default:         ;
            endcase
        end
    end

    // Step logic
    avfd_step u_step (
        .st          (st_reg),
        .rx_byte     (rx_byte_reg),
        .max_total   (max_total_reg),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .st_next     (st_next),
        .res         (step_res)
    );

    // A buffered word moves on unless it has a result and the output is full
    assign out_free = !res_reg.valid || out_ready;
    assign advance  = in_valid_reg && (!step_res.valid || out_free);
    assign in_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            rx_byte_reg <= rx_byte;
    end

    // Deframer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (advance)
            st_reg <= st_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_reg <= '0;
        else if (out_free)
        begin
            if (advance && step_res.valid)
                res_reg <= step_res;
            else
                res_reg.valid <= 1'b0;
        end
    end

    assign out_valid    = res_reg.valid;
    assign out_byte     = res_reg.out_byte;
    assign out_kind     = res_reg.out_kind;
    assign section_last = res_reg.section_last;
    assign frame_last   = res_reg.frame_last;
    assign error_code   = res_reg.error_code;

    // Checks
    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_kind == KIND_ERROR) == (error_code != ERR_NONE)))
        else $error("error kind and error code disagree");

    a_frame_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_last) |->
            (out_kind == KIND_AUDIO || out_kind == KIND_FRAME_END))
        else $error("frame end on a word that cannot close a frame");

    a_section_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && section_last) |->
            (out_kind == KIND_VIDEO || out_kind == KIND_AUDIO))
        else $error("section end on a marker or error word");

    a_hunt_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.valid && (step_res.frame_last
            || step_res.out_kind == KIND_ERROR))
        |=> (st_reg.phase == PH_HUNT && !st_reg.window_valid))
        else $error("deframer did not return to sync hunting");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("stalled result word lost");

endmodule
